FILE: rtl/ps2mt_pkg.sv
`default_nettype none

package ps2mt_pkg;

  // motion accumulator geometry
  localparam int ACCUM_WIDTH = 16;
  localparam int DIVISOR     = 4;
  // wide enough for a doubled cell count taken back out of a full accumulator
  localparam int WIDE_W      = ACCUM_WIDTH + 4;

  // cursor geometry (row shares the column datapath, upper bit unused)
  localparam int POS_W = 7;
  localparam int ROW_W = 6;

  localparam logic [POS_W-1:0] HOME_COLUMN = POS_W'(40);
  localparam logic [ROW_W-1:0] HOME_ROW    = ROW_W'(12);

  // register defaults
  localparam logic [7:0]       BOOST_RESET  = 8'd6;
  localparam logic [POS_W-1:0] COLUMN_RESET = POS_W'(79);
  localparam logic [ROW_W-1:0] ROW_RESET    = ROW_W'(24);

  // register indexes
  localparam logic [1:0] REG_BOOST_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_COLUMN_LIMIT    = 2'd1;
  localparam logic [1:0] REG_ROW_LIMIT       = 2'd2;

  // item functions
  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // byte fields
  localparam int SYNC_BIT = 3;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [1:0]       buttons;
    logic [1:0]       clicks;
    logic             mid_packet;
  } out_item_t;

  // saturate a wide signed value to the accumulator range
  function automatic logic signed [ACCUM_WIDTH-1:0] sat_accum(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((64'sd1 <<< (ACCUM_WIDTH - 1)) - 64'sd1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      sat_accum = hi[ACCUM_WIDTH-1:0];
    end else if (v < lo) begin
      sat_accum = lo[ACCUM_WIDTH-1:0];
    end else begin
      sat_accum = v[ACCUM_WIDTH-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ps2mt_axis.sv
`default_nettype none

module ps2mt_axis (
  input  wire logic signed [ps2mt_pkg::ACCUM_WIDTH-1:0] accum,
  input  wire logic signed [8:0]                        delta,
  input  wire logic [ps2mt_pkg::POS_W-1:0]              pos,
  input  wire logic [ps2mt_pkg::POS_W-1:0]              limit,
  input  wire logic [7:0]                               boost_threshold,
  output logic signed [ps2mt_pkg::ACCUM_WIDTH-1:0]      accum_next,
  output logic [ps2mt_pkg::POS_W-1:0]                   pos_next
);

  localparam int WW = ps2mt_pkg::WIDE_W;

  logic signed [WW-1:0]                        sum_w;
  logic signed [ps2mt_pkg::ACCUM_WIDTH-1:0]    acc_sat;
  logic signed [WW-1:0]                        acc_w;
  logic signed [WW-1:0]                        whole_base;
  logic signed [WW-1:0]                        mag;
  logic signed [WW-1:0]                        bound;
  logic signed [WW-1:0]                        whole;
  logic signed [WW-1:0]                        rem;
  logic signed [WW-1:0]                        pos_w;
  logic signed [WW-1:0]                        limit_w;

  // accumulate and saturate
  assign sum_w   = WW'(accum) + WW'(delta);
  assign acc_sat = ps2mt_pkg::sat_accum(sum_w);
  assign acc_w   = WW'(acc_sat);

  // whole cells, truncated toward zero
  assign whole_base = WW'(acc_w / ps2mt_pkg::DIVISOR);

  // boost when the magnitude passes the threshold
  assign mag   = (acc_w < 0) ? -acc_w : acc_w;
  assign bound = $signed({{(WW-8){1'b0}}, boost_threshold}) * WW'(ps2mt_pkg::DIVISOR);
  assign whole = (mag > bound) ? (whole_base <<< 1) : whole_base;

  // take the cells back out of the accumulator
  assign rem        = acc_w - WW'(whole * ps2mt_pkg::DIVISOR);
  assign accum_next = ps2mt_pkg::sat_accum(rem);

  // move and clamp to [0, limit]
  assign pos_w   = $signed({{(WW-ps2mt_pkg::POS_W){1'b0}}, pos}) + whole;
  assign limit_w = $signed({{(WW-ps2mt_pkg::POS_W){1'b0}}, limit});

  always_comb begin
    if (pos_w < 0) begin
      pos_next = '0;
    end else if (pos_w > limit_w) begin
      pos_next = limit;
    end else begin
      pos_next = pos_w[ps2mt_pkg::POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ps2_mouse_packet_tracker.sv
// result path: each item passes the input register, then the result register
// throughput: one item per cycle; a result waiting on result_stall holds one more item
// in the input register before item_stall rises
// reset: synchronous, active high; cursor homes to column 40 row 12, framing and
// accumulators clear, registers return to threshold 6, limits 79 and 24
`default_nettype none

module ps2_mouse_packet_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire ps2mt_pkg::in_item_t   item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output ps2mt_pkg::out_item_t       result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);

  localparam int AW = ps2mt_pkg::ACCUM_WIDTH;
  localparam int PW = ps2mt_pkg::POS_W;
  localparam int RW = ps2mt_pkg::ROW_W;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // configuration registers
  logic [7:0]    boost_threshold;
  logic [PW-1:0] column_limit;
  logic [RW-1:0] row_limit;

  // pipeline registers
  logic                 in_full;
  ps2mt_pkg::in_item_t  in_q;
  logic                 advance;

  // tracker state
  phase_t                packet_phase, packet_phase_next;
  logic [1:0]            first_byte_buttons, first_byte_buttons_next;
  logic [7:0]            second_byte, second_byte_next;
  logic [PW-1:0]         column_pos, column_pos_next;
  logic [RW-1:0]         row_pos, row_pos_next;
  logic signed [AW-1:0]  column_accum, column_accum_next;
  logic signed [AW-1:0]  row_accum, row_accum_next;
  logic [1:0]            previous_buttons, previous_buttons_next;
  logic [1:0]            click_latch, click_latch_next;
  logic [1:0]            clicks_next;

  // axis datapath
  logic signed [8:0]     col_delta;
  logic signed [8:0]     row_delta;
  logic signed [AW-1:0]  col_acc_upd;
  logic signed [AW-1:0]  row_acc_upd;
  logic [PW-1:0]         col_pos_upd;
  logic [PW-1:0]         row_pos_upd;

  // handshake
  assign cfg_ready  = 1'b1;
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && result_valid && result_stall;

  // column adds x, row subtracts y
  assign col_delta = $signed({second_byte[7], second_byte});
  assign row_delta = 9'sd0 - $signed({in_q.data_byte[7], in_q.data_byte});

  ps2mt_axis u_col (
    .accum           (column_accum),
    .delta           (col_delta),
    .pos             (column_pos),
    .limit           (column_limit),
    .boost_threshold (boost_threshold),
    .accum_next      (col_acc_upd),
    .pos_next        (col_pos_upd)
  );

  ps2mt_axis u_row (
    .accum           (row_accum),
    .delta           (row_delta),
    .pos             ({1'b0, row_pos}),
    .limit           ({1'b0, row_limit}),
    .boost_threshold (boost_threshold),
    .accum_next      (row_acc_upd),
    .pos_next        (row_pos_upd)
  );

  // next state for the item in the input register
  always_comb begin
    packet_phase_next       = packet_phase;
    first_byte_buttons_next = first_byte_buttons;
    second_byte_next        = second_byte;
    column_pos_next         = column_pos;
    row_pos_next            = row_pos;
    column_accum_next       = column_accum;
    row_accum_next          = row_accum;
    previous_buttons_next   = previous_buttons;
    click_latch_next        = click_latch;
    clicks_next             = 2'b00;
    if (in_q.func == ps2mt_pkg::FUNC_READ) begin
      clicks_next      = click_latch;
      click_latch_next = 2'b00;
    end else begin
      unique case (packet_phase)
        PH_SECOND: begin
          second_byte_next  = in_q.data_byte;
          packet_phase_next = PH_THIRD;
        end
        PH_THIRD: begin
          packet_phase_next     = PH_FIRST;
          column_accum_next     = col_acc_upd;
          row_accum_next        = row_acc_upd;
          column_pos_next       = col_pos_upd;
          row_pos_next          = row_pos_upd[RW-1:0];
          click_latch_next      = click_latch | (first_byte_buttons & ~previous_buttons);
          previous_buttons_next = first_byte_buttons;
        end
        default: begin
          // first byte: keep only when the sync bit is set
          if (in_q.data_byte[ps2mt_pkg::SYNC_BIT]) begin
            first_byte_buttons_next = in_q.data_byte[1:0];
            packet_phase_next       = PH_SECOND;
          end else begin
            packet_phase_next = PH_FIRST;
          end
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_threshold <= ps2mt_pkg::BOOST_RESET;
      column_limit    <= ps2mt_pkg::COLUMN_RESET;
      row_limit       <= ps2mt_pkg::ROW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ps2mt_pkg::REG_BOOST_THRESHOLD: boost_threshold <= cfg_data;
        ps2mt_pkg::REG_COLUMN_LIMIT:    column_limit    <= cfg_data[PW-1:0];
        ps2mt_pkg::REG_ROW_LIMIT:       row_limit       <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= item;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase       <= PH_FIRST;
      first_byte_buttons <= 2'b00;
      second_byte        <= 8'h00;
      column_pos         <= ps2mt_pkg::HOME_COLUMN;
      row_pos            <= ps2mt_pkg::HOME_ROW;
      column_accum       <= '0;
      row_accum          <= '0;
      previous_buttons   <= 2'b00;
      click_latch        <= 2'b00;
      result_valid       <= 1'b0;
    end else begin
      if (advance) begin
        packet_phase       <= packet_phase_next;
        first_byte_buttons <= first_byte_buttons_next;
        second_byte        <= second_byte_next;
        column_pos         <= column_pos_next;
        row_pos            <= row_pos_next;
        column_accum       <= column_accum_next;
        row_accum          <= row_accum_next;
        previous_buttons   <= previous_buttons_next;
        click_latch        <= click_latch_next;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.cursor_column <= column_pos_next;
      result.cursor_row    <= row_pos_next;
      result.buttons       <= previous_buttons_next;
      result.clicks        <= clicks_next;
      result.mid_packet    <= (packet_phase_next != PH_FIRST);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ps2mt_checker.sv
`default_nettype none

module ps2mt_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_valid,
  input wire logic                 item_stall,
  input wire ps2mt_pkg::in_item_t  item,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire ps2mt_pkg::out_item_t result,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [1:0]           cfg_index,
  input wire logic [7:0]           cfg_data
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stall without a stalled result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("pipeline not empty after reset");

  // a result taken with the pipe otherwise empty leaves no result behind
  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !item_stall && !item_valid &&
    $past(!item_valid || item_stall) && !$past(rst) && $past(!result_valid)
    |=> !result_valid)
    else $error("result repeated");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (.*);

`default_nettype wire

FILE: verif/ps2_mouse_packet_tracker_tb.sv
`default_nettype none

module ps2_mouse_packet_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // framing phases of the tracker's own copy
  localparam logic [1:0] WAIT_SYNC = 2'd0;
  localparam logic [1:0] WAIT_X    = 2'd1;
  localparam logic [1:0] WAIT_Y    = 2'd2;

  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES  = 8;
  localparam int ITEMS_PER_SET = 285;
  localparam int SETTINGS_RUN  = 4;
  localparam int DIRECTED_ROWS = 23;

  // one directed row: pin set means the typed report is checked as is
  typedef struct packed {
    logic       pin;
    logic       func;
    logic [7:0] data;
    logic [6:0] col;
    logic [5:0] row;
    logic [1:0] btn;
    logic [1:0] clk_edges;
    logic       mid;
  } step_t;

  localparam step_t OPENING [DIRECTED_ROWS] = '{
    // read right after reset
    '{1'b1, ps2mt_pkg::FUNC_READ, 8'h00, 7'd40, 6'd12, 2'd0, 2'd0, 1'b0},
    // bad sync bytes, all-zero and all bits but sync
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h00, 7'd40, 6'd12, 2'd0, 2'd0, 1'b0},
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'hF7, 7'd40, 6'd12, 2'd0, 2'd0, 1'b0},
    // null packet
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h08, 7'd40, 6'd12, 2'd0, 2'd0, 1'b1},
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h00, 7'd40, 6'd12, 2'd0, 2'd0, 1'b1},
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h00, 7'd40, 6'd12, 2'd0, 2'd0, 1'b0},
    // both buttons, full positive x, full negative y: clamps at both limits
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h0B, 7'd40, 6'd12, 2'd0, 2'd0, 1'b1},
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h7F, 7'd40, 6'd12, 2'd0, 2'd0, 1'b1},
    '{1'b1, ps2mt_pkg::FUNC_FEED, 8'h80, 7'd79, 6'd24, 2'd3, 2'd0, 1'b0},
    // read returns both edges, then the latch is clear
    '{1'b1, ps2mt_pkg::FUNC_READ, 8'hFF, 7'd79, 6'd24, 2'd3, 2'd3, 1'b0},
    '{1'b1, ps2mt_pkg::FUNC_READ, 8'h00, 7'd79, 6'd24, 2'd3, 2'd0, 1'b0},
    // sign bits in the first byte, full negative x, read in mid packet
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h3D, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h80, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_READ, 8'h55, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h7F, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_READ, 8'h00, '0, '0, '0, '0, 1'b0},
    // small moves and button changes
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h09, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h01, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'hFF, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h0A, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'hFE, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_FEED, 8'h02, '0, '0, '0, '0, 1'b0},
    '{1'b0, ps2mt_pkg::FUNC_READ, 8'hAA, '0, '0, '0, '0, 1'b0}
  };

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  ps2mt_pkg::in_item_t  item;
  logic                 result_valid;
  logic                 result_stall;
  ps2mt_pkg::out_item_t result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [7:0]           cfg_data;

  // typed expectation riding along with the item being driven
  logic                 pin_valid;
  ps2mt_pkg::out_item_t pin_report;

  int          send_idle;
  int          stall_pct;
  int          failures;
  int          items_taken;
  int          reports_seen;
  int          clicks_seen;
  int          reg_writes;

  ps2mt_pkg::out_item_t reports_due[$];

  // tracker copy: settings and state
  logic [7:0]  boost_cfg;
  logic [6:0]  col_lim;
  logic [5:0]  row_lim;
  logic [1:0]  phase;
  logic [1:0]  lead_buttons;
  logic [7:0]  x_byte;
  int          col_pos;
  int          row_pos;
  int          col_acc;
  int          row_acc;
  logic [1:0]  held_buttons;
  logic [1:0]  click_hold;

  ps2_mouse_packet_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // saturate to the accumulator's signed range
  function automatic int clamp_motion(int v);
    int hi;
    int lo;
    hi = (1 << (ps2mt_pkg::ACCUM_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // whole cells in an accumulator, doubled past the boost threshold
  function automatic int cells_from(int acc);
    int whole;
    int mag;
    whole = acc / ps2mt_pkg::DIVISOR;
    mag = (acc < 0) ? -acc : acc;
    if (mag > int'(boost_cfg) * ps2mt_pkg::DIVISOR) whole = whole * 2;
    return whole;
  endfunction

  function automatic int clamp_cursor(int p, int lim);
    if (p < 0) return 0;
    if (p > lim) return lim;
    return p;
  endfunction

  // advance the tracker copy by one item and report what it shows
  function automatic ps2mt_pkg::out_item_t track_item(ps2mt_pkg::in_item_t it);
    ps2mt_pkg::out_item_t rep;
    int dc;
    int dr;
    logic [1:0] nb;
    rep.clicks = '0;
    if (it.func == ps2mt_pkg::FUNC_READ) begin
      rep.clicks = click_hold;
      click_hold = '0;
    end else begin
      case (phase)
        WAIT_X: begin
          x_byte = it.data_byte;
          phase = WAIT_Y;
        end
        WAIT_Y: begin
          nb = lead_buttons;
          phase = WAIT_SYNC;
          col_acc = clamp_motion(col_acc + int'($signed(x_byte)));
          row_acc = clamp_motion(row_acc - int'($signed(it.data_byte)));
          dc = cells_from(col_acc);
          col_acc = clamp_motion(col_acc - dc * ps2mt_pkg::DIVISOR);
          dr = cells_from(row_acc);
          row_acc = clamp_motion(row_acc - dr * ps2mt_pkg::DIVISOR);
          col_pos = clamp_cursor(col_pos + dc, int'(col_lim));
          row_pos = clamp_cursor(row_pos + dr, int'(row_lim));
          click_hold = click_hold | (nb & ~held_buttons);
          held_buttons = nb;
        end
        default: begin
          if (it.data_byte[ps2mt_pkg::SYNC_BIT]) begin
            lead_buttons = it.data_byte[1:0];
            phase = WAIT_X;
          end else begin
            phase = WAIT_SYNC;
          end
        end
      endcase
    end
    rep.cursor_column = col_pos[ps2mt_pkg::POS_W-1:0];
    rep.cursor_row = row_pos[ps2mt_pkg::ROW_W-1:0];
    rep.buttons = held_buttons;
    rep.mid_packet = (phase != WAIT_SYNC);
    return rep;
  endfunction

  // predict on every accepted item, check every accepted report
  always @(posedge clk) begin : watch
    ps2mt_pkg::out_item_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        want = track_item(item);
        if (pin_valid) want = pin_report;
        reports_due.push_back(want);
        items_taken++;
      end
      if (result_valid && !result_stall) begin
        reports_seen++;
        if (result.clicks != '0) clicks_seen++;
        if (reports_due.size() == 0) begin
          $error("report with no item pending: %h", result);
          failures++;
        end else begin
          want = reports_due.pop_front();
          if (result.cursor_column !== want.cursor_column) begin
            $error("cursor_column: expected %0d, got %0d", want.cursor_column,
                   result.cursor_column);
            failures++;
          end
          if (result.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, result.cursor_row);
            failures++;
          end
          if (result.buttons !== want.buttons) begin
            $error("buttons: expected %0d, got %0d", want.buttons, result.buttons);
            failures++;
          end
          if (result.clicks !== want.clicks) begin
            $error("clicks: expected %0d, got %0d", want.clicks, result.clicks);
            failures++;
          end
          if (result.mid_packet !== want.mid_packet) begin
            $error("mid_packet: expected %0d, got %0d", want.mid_packet, result.mid_packet);
            failures++;
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // drive one item, idling first at the current rate, until it is taken
  task automatic send_item(ps2mt_pkg::in_item_t it, logic pin, ps2mt_pkg::out_item_t want);
    item <= it;
    pin_valid <= pin;
    pin_report <= want;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ps2mt_pkg::REG_BOOST_THRESHOLD: boost_cfg = val;
      ps2mt_pkg::REG_COLUMN_LIMIT:    col_lim = val[6:0];
      ps2mt_pkg::REG_ROW_LIMIT:       row_lim = val[5:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // stop sending and let every pending report come home
  task automatic settle();
    item_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic ps2mt_pkg::in_item_t feed_item(logic [7:0] b);
    ps2mt_pkg::in_item_t it;
    it.func = ps2mt_pkg::FUNC_FEED;
    it.data_byte = b;
    return it;
  endfunction

  function automatic ps2mt_pkg::in_item_t read_item();
    ps2mt_pkg::in_item_t it;
    it.func = ps2mt_pkg::FUNC_READ;
    it.data_byte = 8'($urandom_range(255));
    return it;
  endfunction

  // motion byte, leaning on the extremes now and then
  function automatic logic [7:0] motion_byte();
    logic [7:0] picks [5];
    picks = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(9) < 3) return picks[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  // mostly whole packets with random content, some reads and stray bytes
  task automatic send_random(int quota);
    int n;
    int kind;
    n = 0;
    while (n < quota) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(9) == 0) begin
            send_item(read_item(), 1'b0, '0);
            n++;
          end
          if (k == 0) send_item(feed_item(8'($urandom_range(255)) | 8'h08), 1'b0, '0);
          else send_item(feed_item(motion_byte()), 1'b0, '0);
          n++;
        end
      end else if (kind < 86) begin
        send_item(read_item(), 1'b0, '0);
        n++;
      end else begin
        send_item(feed_item(8'($urandom_range(255))), 1'b0, '0);
        n++;
      end
    end
  endtask

  initial begin : stimulus
    ps2mt_pkg::out_item_t want;
    ps2mt_pkg::in_item_t it;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_valid = 1'b0;
    pin_report = '0;
    send_idle = 0;
    stall_pct = 0;
    failures = 0;
    items_taken = 0;
    reports_seen = 0;
    clicks_seen = 0;
    reg_writes = 0;

    // tracker copy at its reset values
    boost_cfg = ps2mt_pkg::BOOST_RESET;
    col_lim = ps2mt_pkg::COLUMN_RESET;
    row_lim = ps2mt_pkg::ROW_RESET;
    phase = WAIT_SYNC;
    lead_buttons = '0;
    x_byte = '0;
    col_pos = int'(ps2mt_pkg::HOME_COLUMN);
    row_pos = int'(ps2mt_pkg::HOME_ROW);
    col_acc = 0;
    row_acc = 0;
    held_buttons = '0;
    click_hold = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed opening at reset settings
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      it.func = OPENING[i].func;
      it.data_byte = OPENING[i].data;
      want.cursor_column = OPENING[i].col;
      want.cursor_row = OPENING[i].row;
      want.buttons = OPENING[i].btn;
      want.clicks = OPENING[i].clk_edges;
      want.mid_packet = OPENING[i].mid;
      send_item(it, OPENING[i].pin, want);
    end

    // one register setting and one idling pattern per set
    for (int ph = 0; ph < SETTINGS_RUN; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(ps2mt_pkg::REG_BOOST_THRESHOLD, 8'h00);
          write_reg(ps2mt_pkg::REG_COLUMN_LIMIT, 8'hFF);
          write_reg(ps2mt_pkg::REG_ROW_LIMIT, 8'hFF);
          send_idle = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(ps2mt_pkg::REG_BOOST_THRESHOLD, 8'hFF);
          write_reg(ps2mt_pkg::REG_COLUMN_LIMIT, 8'h00);
          write_reg(ps2mt_pkg::REG_ROW_LIMIT, 8'h00);
          send_idle = 84;
          stall_pct = 0;
        end
        2: begin
          write_reg(REG_UNUSED, 8'h5A);
          write_reg(ps2mt_pkg::REG_BOOST_THRESHOLD, 8'd3);
          write_reg(ps2mt_pkg::REG_COLUMN_LIMIT, 8'd20);
          write_reg(ps2mt_pkg::REG_ROW_LIMIT, 8'd10);
          send_idle = 0;
          stall_pct = 84;
        end
        default: begin
          write_reg(ps2mt_pkg::REG_BOOST_THRESHOLD, 8'($urandom_range(255)));
          write_reg(ps2mt_pkg::REG_COLUMN_LIMIT, 8'($urandom_range(255)));
          write_reg(ps2mt_pkg::REG_ROW_LIMIT, 8'($urandom_range(255)));
          send_idle = 29;
          stall_pct = 29;
        end
      endcase
      cfg_valid <= 1'b0;
      send_random(ITEMS_PER_SET);
    end

    settle();
    $display("covered %0d items and %0d cursor reports over %0d register settings",
             items_taken, reports_seen, SETTINGS_RUN + 1);
    $display("%0d reads returned button edges, %0d register writes", clicks_seen, reg_writes);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
